// ===== hdl/lavm_pkg.sv =====
// ----------------------------------------------------------------------------
// lavm_pkg: shared types and constants for the look-at view matrix unit
// Fixed-point formats, pipeline depths and vector types used by the top, normalizer, cross and shift modules.
// ----------------------------------------------------------------------------
package lavm_pkg;

    // Q2.30 fraction bits and the unit value
    localparam int FRAC_BITS = 30;
    localparam logic [31:0] ONE_Q30 = 32'h4000_0000;

    // Normalized magnitude width and iterative unit widths
    localparam int MAG_BITS  = 30;
    localparam int SQRT_BITS = 31;
    localparam int QUO_BITS  = 31;
    localparam int REM_W     = 64;

    // Component widths seen by the two normalizers
    localparam int AIM_W   = 33;
    localparam int CROSS_W = 64;

    // Stage counts of each unit
    localparam int NORM_LAT  = 5 + SQRT_BITS + 1 + QUO_BITS + 1;
    localparam int CROSS_LAT = 2;
    localparam int ROUND_LAT = 1;
    localparam int SHIFT_LAT = 3;

    // Three-component vectors, element 0 is x
    typedef logic [2:0][31:0] t_vec;
    typedef logic [2:0][63:0] t_wide;

endpackage

// ===== hdl/look_at_view_matrix_top.sv =====
// ----------------------------------------------------------------------------
// look_at_view_matrix_top: look-at view matrix unit
// A request is taken on every cycle that start is high; busy never rises.
// Each result appears on the output ports for exactly one cycle with o_valid
// high, and the receiver cannot stall it. A request passes through the input
// register, the two normalizers (69 stages each: a one-bit-per-stage
// square root and a one-bit-per-stage divider), the two cross products, the
// rounding of the second basis row and the three-stage translation unit.
// ----------------------------------------------------------------------------
module look_at_view_matrix_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_action,
    input  logic [31:0] i_pos_x,
    input  logic [31:0] i_pos_y,
    input  logic [31:0] i_pos_z,
    input  logic [31:0] i_aim_x,
    input  logic [31:0] i_aim_y,
    input  logic [31:0] i_aim_z,
    input  logic [31:0] i_up_x,
    input  logic [31:0] i_up_y,
    input  logic [31:0] i_up_z,
    output logic        o_valid,
    output logic [31:0] o_right_x,
    output logic [31:0] o_right_y,
    output logic [31:0] o_right_z,
    output logic [31:0] o_upward_x,
    output logic [31:0] o_upward_y,
    output logic [31:0] o_upward_z,
    output logic [31:0] o_forward_x,
    output logic [31:0] o_forward_y,
    output logic [31:0] o_forward_z,
    output logic [31:0] o_shift_x,
    output logic [31:0] o_shift_y,
    output logic [31:0] o_shift_z
);

    localparam int AW = lavm_pkg::AIM_W;
    localparam int FB = lavm_pkg::FRAC_BITS;

    lavm_pkg::t_vec       in_pos;
    lavm_pkg::t_vec       in_aim;
    lavm_pkg::t_vec       in_up;
    logic [2:0][AW-1:0]   n_aim;

    logic                 r_in_v;
    logic [2:0][AW-1:0]   r_aim;
    lavm_pkg::t_vec       r_pos;
    lavm_pkg::t_vec       r_up;

    logic                 w_valid;
    lavm_pkg::t_vec       w_vec;
    lavm_pkg::t_vec       pos_a;
    lavm_pkg::t_vec       up_a;
    logic                 cu_valid;
    lavm_pkg::t_wide      cu;
    lavm_pkg::t_vec       w_b;
    lavm_pkg::t_vec       pos_b;
    logic                 u_valid;
    lavm_pkg::t_vec       u_vec;
    lavm_pkg::t_vec       w_c;
    lavm_pkg::t_vec       pos_c;
    logic                 cv_valid;
    lavm_pkg::t_wide      cv;
    lavm_pkg::t_vec       u_d;
    lavm_pkg::t_vec       w_d;
    lavm_pkg::t_vec       pos_d;
    logic                 r_v_valid;
    lavm_pkg::t_vec       r_v_vec;
    lavm_pkg::t_vec       n_v_vec;
    logic                 sh_valid;
    lavm_pkg::t_vec       sh_vec;
    lavm_pkg::t_vec       u_e;
    lavm_pkg::t_vec       v_e;
    lavm_pkg::t_vec       w_e;

    assign busy   = 1'b0;
    assign in_pos = {i_pos_z, i_pos_y, i_pos_x};
    assign in_aim = {i_aim_z, i_aim_y, i_aim_x};
    assign in_up  = {i_up_z, i_up_y, i_up_x};

    // when i_action is set, turn a target point into a direction
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (i_action) begin
                n_aim[i] = {in_aim[i][31], in_aim[i]} - {in_pos[i][31], in_pos[i]};
            end else begin
                n_aim[i] = {in_aim[i][31], in_aim[i]};
            end
        end
    end

    // hold the request in the input stage
    always_ff @(posedge i_clk) begin
        r_aim <= n_aim;
        r_pos <= in_pos;
        r_up  <= in_up;
    end

    // forward row
    lavm_norm #(.CW(lavm_pkg::AIM_W)) u_norm_w (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_in_v),
        .i_vec   (r_aim),
        .o_valid (w_valid),
        .o_vec   (w_vec)
    );

    lavm_delay #(.W(192), .D(lavm_pkg::NORM_LAT)) u_dly_a (
        .i_clk (i_clk),
        .i_d   ({r_pos, r_up}),
        .o_q   ({pos_a, up_a})
    );

    // cross(w, up)
    lavm_cross u_cross_u (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_valid),
        .i_a     (w_vec),
        .i_b     (up_a),
        .o_valid (cu_valid),
        .o_c     (cu)
    );

    lavm_delay #(.W(192), .D(lavm_pkg::CROSS_LAT)) u_dly_b (
        .i_clk (i_clk),
        .i_d   ({w_vec, pos_a}),
        .o_q   ({w_b, pos_b})
    );

    // right row
    lavm_norm #(.CW(lavm_pkg::CROSS_W)) u_norm_u (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (cu_valid),
        .i_vec   (cu),
        .o_valid (u_valid),
        .o_vec   (u_vec)
    );

    lavm_delay #(.W(192), .D(lavm_pkg::NORM_LAT)) u_dly_c (
        .i_clk (i_clk),
        .i_d   ({w_b, pos_b}),
        .o_q   ({w_c, pos_c})
    );

    // cross(w, u)
    lavm_cross u_cross_v (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (u_valid),
        .i_a     (w_c),
        .i_b     (u_vec),
        .o_valid (cv_valid),
        .o_c     (cv)
    );

    lavm_delay #(.W(288), .D(lavm_pkg::CROSS_LAT + lavm_pkg::ROUND_LAT)) u_dly_d (
        .i_clk (i_clk),
        .i_d   ({u_vec, w_c, pos_c}),
        .o_q   ({u_d, w_d, pos_d})
    );

    // round the upward row to Q2.30 and clamp to unit range
    always_comb begin
        logic [63:0] mag;
        logic [33:0] rnd;
        logic [31:0] lim;
        for (int i = 0; i < 3; i++) begin
            mag = cv[i][63] ? (64'(0) - cv[i]) : cv[i];
            rnd = 34'((mag + (64'(1) << (FB - 1))) >> FB);
            lim = (rnd > 34'(lavm_pkg::ONE_Q30)) ? lavm_pkg::ONE_Q30 : rnd[31:0];
            n_v_vec[i] = cv[i][63] ? (32'(0) - lim) : lim;
        end
    end

    always_ff @(posedge i_clk) begin
        r_v_vec <= n_v_vec;
    end

    // translation column
    lavm_shift u_shift (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v_valid),
        .i_u     (u_d),
        .i_v     (r_v_vec),
        .i_w     (w_d),
        .i_pos   (pos_d),
        .o_valid (sh_valid),
        .o_shift (sh_vec)
    );

    lavm_delay #(.W(288), .D(lavm_pkg::SHIFT_LAT)) u_dly_e (
        .i_clk (i_clk),
        .i_d   ({u_d, r_v_vec, w_d}),
        .o_q   ({u_e, v_e, w_e})
    );

    // advance valid bits of the local stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v    <= 1'b0;
            r_v_valid <= 1'b0;
        end else begin
            r_in_v    <= start & ~busy;
            r_v_valid <= cv_valid;
        end
    end

    assign o_valid     = sh_valid;
    assign o_right_x   = u_e[0];
    assign o_right_y   = u_e[1];
    assign o_right_z   = u_e[2];
    assign o_upward_x  = v_e[0];
    assign o_upward_y  = v_e[1];
    assign o_upward_z  = v_e[2];
    assign o_forward_x = w_e[0];
    assign o_forward_y = w_e[1];
    assign o_forward_z = w_e[2];
    assign o_shift_x   = sh_vec[0];
    assign o_shift_y   = sh_vec[1];
    assign o_shift_z   = sh_vec[2];

endmodule

// ===== hdl/lavm_delay.sv =====
// ----------------------------------------------------------------------------
// lavm_delay: fixed-length delay line
// Carries side payload alongside a pipeline so that it lines up at the end.
// ----------------------------------------------------------------------------
module lavm_delay #(
    parameter int W = 1,
    parameter int D = 1
) (
    input  logic         i_clk,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_q
);

    logic [W-1:0] r_tap [D];

    // advance the taps every cycle
    always_ff @(posedge i_clk) begin
        r_tap[0] <= i_d;
        for (int i = 1; i < D; i++) begin
            r_tap[i] <= r_tap[i-1];
        end
    end

    assign o_q = r_tap[D-1];

endmodule

// ===== hdl/lavm_norm.sv =====
// ----------------------------------------------------------------------------
// lavm_norm: pipelined vector normalizer
// Scales the vector so its largest magnitude sits in [2^29, 2^30), takes the
// floor square root of the sum of squares one bit per stage, then divides
// each component by the length one quotient bit per stage. Output is Q2.30.
// ----------------------------------------------------------------------------
module lavm_norm #(
    parameter int CW = lavm_pkg::AIM_W
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic [2:0][CW-1:0]    i_vec,
    output logic                  o_valid,
    output lavm_pkg::t_vec        o_vec
);

    localparam int BLW  = $clog2(CW + 1);
    localparam int MB   = lavm_pkg::MAG_BITS;
    localparam int SB   = lavm_pkg::SQRT_BITS;
    localparam int QB   = lavm_pkg::QUO_BITS;
    localparam int REMW = lavm_pkg::REM_W;

    // stage A: magnitudes and signs
    logic                 r_a_v;
    logic [2:0][CW-1:0]   r_a_mag;
    logic [2:0]           r_a_neg;
    // stage B: bit length of the largest magnitude
    logic                 r_b_v;
    logic [BLW-1:0]       r_b_bl;
    logic [2:0][CW-1:0]   r_b_mag;
    logic [2:0]           r_b_neg;
    // stage C: scaled magnitudes
    logic                 r_c_v;
    logic [2:0][MB-1:0]   r_c_m;
    logic [2:0]           r_c_neg;
    // stage D: squares
    logic                 r_d_v;
    logic [2:0][2*MB-1:0] r_d_sq;
    logic [2:0][MB-1:0]   r_d_m;
    logic [2:0]           r_d_neg;

    // square root stages, index 0 holds the sum of squares
    logic                 r_s_v   [SB+1];
    logic [REMW-1:0]      r_s_rem [SB+1];
    logic [SB-1:0]        r_s_res [SB+1];
    logic [2:0][MB-1:0]   r_s_m   [SB+1];
    logic [2:0]           r_s_neg [SB+1];
    logic [REMW-1:0]      n_s_rem [SB+1];
    logic [SB-1:0]        n_s_res [SB+1];

    // divider stages, index 0 holds numerators and the length
    logic                   r_q_v    [QB+1];
    logic [2:0][REMW-1:0]   r_q_rem  [QB+1];
    logic [2:0][QB-1:0]     r_q_quo  [QB+1];
    logic [SB-1:0]          r_q_den  [QB+1];
    logic                   r_q_zero [QB+1];
    logic [2:0]             r_q_neg  [QB+1];
    logic [2:0][REMW-1:0]   n_q_rem  [QB+1];
    logic [2:0][QB-1:0]     n_q_quo  [QB+1];

    // output stage
    logic                 r_o_v;
    lavm_pkg::t_vec       r_o_vec;

    logic [2:0][CW-1:0]   n_a_mag;
    logic [CW-1:0]        b_or;
    logic [BLW-1:0]       n_b_bl;
    logic [2:0][MB-1:0]   n_c_m;
    lavm_pkg::t_vec       n_o_vec;

    // take magnitudes
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_a_mag[i] = i_vec[i][CW-1] ? (CW'(0) - i_vec[i]) : i_vec[i];
        end
    end

    // find the bit length of the largest magnitude
    always_comb begin
        b_or   = r_a_mag[0] | r_a_mag[1] | r_a_mag[2];
        n_b_bl = '0;
        for (int i = 0; i < CW; i++) begin
            if (b_or[i]) begin
                n_b_bl = BLW'(i + 1);
            end
        end
    end

    // scale by 2^(30 - bit length), truncating
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_c_m[i] = MB'(({r_b_mag[i], MB'(0)}) >> r_b_bl);
        end
    end

    // square root: one result bit per stage
    always_comb begin
        logic [REMW-1:0] test;
        int k;
        n_s_rem[0] = REMW'(r_d_sq[0]) + REMW'(r_d_sq[1]) + REMW'(r_d_sq[2]);
        n_s_res[0] = '0;
        for (int g = 0; g < SB; g++) begin
            k    = SB - 1 - g;
            test = (REMW'(r_s_res[g]) << (k + 1)) | (REMW'(1) << (2 * k));
            if (r_s_rem[g] >= test) begin
                n_s_rem[g+1] = r_s_rem[g] - test;
                n_s_res[g+1] = r_s_res[g] | (SB'(1) << k);
            end else begin
                n_s_rem[g+1] = r_s_rem[g];
                n_s_res[g+1] = r_s_res[g];
            end
        end
    end

    // division: one quotient bit per stage
    always_comb begin
        logic [REMW-1:0] dsh;
        int k;
        for (int i = 0; i < 3; i++) begin
            n_q_rem[0][i] = (REMW'(r_s_m[SB][i]) << MB) + REMW'(r_s_res[SB] >> 1);
            n_q_quo[0][i] = '0;
        end
        for (int g = 0; g < QB; g++) begin
            k   = QB - 1 - g;
            dsh = REMW'(r_q_den[g]) << k;
            for (int i = 0; i < 3; i++) begin
                if (r_q_rem[g][i] >= dsh) begin
                    n_q_rem[g+1][i] = r_q_rem[g][i] - dsh;
                    n_q_quo[g+1][i] = r_q_quo[g][i] | (QB'(1) << k);
                end else begin
                    n_q_rem[g+1][i] = r_q_rem[g][i];
                    n_q_quo[g+1][i] = r_q_quo[g][i];
                end
            end
        end
    end

    // apply signs, force a zero basis for a zero vector
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (r_q_zero[QB]) begin
                n_o_vec[i] = '0;
            end else if (r_q_neg[QB][i]) begin
                n_o_vec[i] = 32'(0) - 32'(r_q_quo[QB][i]);
            end else begin
                n_o_vec[i] = 32'(r_q_quo[QB][i]);
            end
        end
    end

    // advance payload
    always_ff @(posedge i_clk) begin
        r_a_mag <= n_a_mag;
        for (int i = 0; i < 3; i++) begin
            r_a_neg[i] <= i_vec[i][CW-1];
        end
        r_b_bl  <= n_b_bl;
        r_b_mag <= r_a_mag;
        r_b_neg <= r_a_neg;
        r_c_m   <= n_c_m;
        r_c_neg <= r_b_neg;
        for (int i = 0; i < 3; i++) begin
            r_d_sq[i] <= r_c_m[i] * r_c_m[i];
        end
        r_d_m   <= r_c_m;
        r_d_neg <= r_c_neg;
        r_s_m[0]   <= r_d_m;
        r_s_neg[0] <= r_d_neg;
        for (int g = 0; g <= SB; g++) begin
            r_s_rem[g] <= n_s_rem[g];
            r_s_res[g] <= n_s_res[g];
        end
        for (int g = 1; g <= SB; g++) begin
            r_s_m[g]   <= r_s_m[g-1];
            r_s_neg[g] <= r_s_neg[g-1];
        end
        r_q_den[0]  <= r_s_res[SB];
        r_q_zero[0] <= (r_s_res[SB] == '0);
        r_q_neg[0]  <= r_s_neg[SB];
        for (int g = 0; g <= QB; g++) begin
            r_q_rem[g] <= n_q_rem[g];
            r_q_quo[g] <= n_q_quo[g];
        end
        for (int g = 1; g <= QB; g++) begin
            r_q_den[g]  <= r_q_den[g-1];
            r_q_zero[g] <= r_q_zero[g-1];
            r_q_neg[g]  <= r_q_neg[g-1];
        end
        r_o_vec <= n_o_vec;
    end

    // advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
            r_d_v <= 1'b0;
            for (int g = 0; g <= SB; g++) begin
                r_s_v[g] <= 1'b0;
            end
            for (int g = 0; g <= QB; g++) begin
                r_q_v[g] <= 1'b0;
            end
            r_o_v <= 1'b0;
        end else begin
            r_a_v    <= i_valid;
            r_b_v    <= r_a_v;
            r_c_v    <= r_b_v;
            r_d_v    <= r_c_v;
            r_s_v[0] <= r_d_v;
            for (int g = 1; g <= SB; g++) begin
                r_s_v[g] <= r_s_v[g-1];
            end
            r_q_v[0] <= r_s_v[SB];
            for (int g = 1; g <= QB; g++) begin
                r_q_v[g] <= r_q_v[g-1];
            end
            r_o_v <= r_q_v[QB];
        end
    end

    assign o_valid = r_o_v;
    assign o_vec   = r_o_vec;

endmodule

// ===== hdl/lavm_cross.sv =====
// ----------------------------------------------------------------------------
// lavm_cross: exact cross product
// Two stages: six 32x32 signed products, then the three differences.
// ----------------------------------------------------------------------------
module lavm_cross (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  lavm_pkg::t_vec  i_a,
    input  lavm_pkg::t_vec  i_b,
    output logic            o_valid,
    output lavm_pkg::t_wide o_c
);

    logic               r_p_v;
    logic signed [63:0] r_p [6];
    logic               r_c_v;
    lavm_pkg::t_wide    r_c;

    // form products, then differences
    always_ff @(posedge i_clk) begin
        r_p[0] <= $signed(i_a[1]) * $signed(i_b[2]);
        r_p[1] <= $signed(i_a[2]) * $signed(i_b[1]);
        r_p[2] <= $signed(i_a[2]) * $signed(i_b[0]);
        r_p[3] <= $signed(i_a[0]) * $signed(i_b[2]);
        r_p[4] <= $signed(i_a[0]) * $signed(i_b[1]);
        r_p[5] <= $signed(i_a[1]) * $signed(i_b[0]);
        r_c[0] <= r_p[0] - r_p[1];
        r_c[1] <= r_p[2] - r_p[3];
        r_c[2] <= r_p[4] - r_p[5];
    end

    // advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_v <= 1'b0;
            r_c_v <= 1'b0;
        end else begin
            r_p_v <= i_valid;
            r_c_v <= r_p_v;
        end
    end

    assign o_valid = r_c_v;
    assign o_c     = r_c;

endmodule

// ===== hdl/lavm_shift.sv =====
// ----------------------------------------------------------------------------
// lavm_shift: translation column
// Forms -dot(row, position) for all three rows: products, sums, then
// rounding half away from zero to Q16.16 and saturation.
// ----------------------------------------------------------------------------
module lavm_shift (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  lavm_pkg::t_vec i_u,
    input  lavm_pkg::t_vec i_v,
    input  lavm_pkg::t_vec i_w,
    input  lavm_pkg::t_vec i_pos,
    output logic           o_valid,
    output lavm_pkg::t_vec o_shift
);

    localparam int FB = lavm_pkg::FRAC_BITS;

    logic               r_p_v;
    logic signed [63:0] r_p [3][3];
    logic               r_s_v;
    logic signed [63:0] r_s [3];
    logic               r_o_v;
    lavm_pkg::t_vec     r_o;

    lavm_pkg::t_vec     row [3];
    lavm_pkg::t_vec     n_o;

    assign row[0] = i_u;
    assign row[1] = i_v;
    assign row[2] = i_w;

    // round, negate and saturate each sum
    always_comb begin
        logic [63:0] mag;
        logic [34:0] rnd;
        for (int r = 0; r < 3; r++) begin
            mag = r_s[r][63] ? (64'(0) - 64'(r_s[r])) : 64'(r_s[r]);
            rnd = 35'((mag + (64'(1) << (FB - 1))) >> FB);
            if (r_s[r][63]) begin
                n_o[r] = (rnd > 35'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : rnd[31:0];
            end else begin
                n_o[r] = (rnd > 35'h0_8000_0000) ? 32'h8000_0000 : (32'(0) - rnd[31:0]);
            end
        end
    end

    // products, sums, result
    always_ff @(posedge i_clk) begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                r_p[r][c] <= $signed(row[r][c]) * $signed(i_pos[c]);
            end
            r_s[r] <= r_p[r][0] + r_p[r][1] + r_p[r][2];
        end
        r_o <= n_o;
    end

    // advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_v <= 1'b0;
            r_s_v <= 1'b0;
            r_o_v <= 1'b0;
        end else begin
            r_p_v <= i_valid;
            r_s_v <= r_p_v;
            r_o_v <= r_s_v;
        end
    end

    assign o_valid = r_o_v;
    assign o_shift = r_o;

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the look-at view matrix unit
// Drives camera requests (directed table, then random) with random gaps and
// compares every result row and translation with a bit-exact predictor.
// ----------------------------------------------------------------------------
module testbench;

    typedef struct packed {
        logic        action;
        logic [31:0] px, py, pz, ax, ay, az, ux, uy, uz;
    } t_cam;

    typedef struct packed {
        logic [31:0] rx, ry, rz, vx, vy, vz, fx, fy, fz, sx, sy, sz;
    } t_view;

    // one directed row; check_fixed marks rows with a typed-in result
    typedef struct {
        t_cam  cam;
        bit    check_fixed;
        t_view fixed;
    } t_row;

    localparam int RAND_ITEMS = 1830;
    localparam logic [31:0] ONE_Q30 = 32'h4000_0000;
    localparam logic [31:0] MIN32 = 32'h8000_0000;
    localparam logic [31:0] MAX32 = 32'h7fff_ffff;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        i_action = 1'b0;
    logic [31:0] i_pos_x = '0, i_pos_y = '0, i_pos_z = '0;
    logic [31:0] i_aim_x = '0, i_aim_y = '0, i_aim_z = '0;
    logic [31:0] i_up_x = '0, i_up_y = '0, i_up_z = '0;
    logic        o_valid;
    logic [31:0] o_right_x, o_right_y, o_right_z;
    logic [31:0] o_upward_x, o_upward_y, o_upward_z;
    logic [31:0] o_forward_x, o_forward_y, o_forward_z;
    logic [31:0] o_shift_x, o_shift_y, o_shift_z;

    t_view pending_views[$];
    int    fail_count = 0;

    // field names by 32-bit slot of t_view, lowest slot first
    string field_names [12] = '{"shift_z", "shift_y", "shift_x",
                                "forward_z", "forward_y", "forward_x",
                                "upward_z", "upward_y", "upward_x",
                                "right_z", "right_y", "right_x"};

    look_at_view_matrix_top dut (.*);

    always #5 i_clk = ~i_clk;

    initial begin
        #50_000_000;
        $display("tb: failure");
        $finish;
    end

    function automatic longint unsigned mag(longint v);
        return v < 0 ? longint'(-v) : longint'(v);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    // scale to a unit vector in Q2.30; zero stays zero
    function automatic void unit_vec(input longint c[3], output longint o[3]);
        longint unsigned m[3], big, sum, len, q;
        int nb;
        big = 0;
        sum = 0;
        nb = 0;
        for (int i = 0; i < 3; i++) begin
            m[i] = mag(c[i]);
            if (m[i] > big) big = m[i];
        end
        if (big == 0) begin
            o = '{0, 0, 0};
            return;
        end
        while (nb < 64 && (big >> nb) != 0) nb++;
        for (int i = 0; i < 3; i++) begin
            if (nb > 30) m[i] >>= (nb - 30);
            else m[i] <<= (30 - nb);
            sum += m[i] * m[i];
        end
        len = int_sqrt(sum);
        for (int i = 0; i < 3; i++) begin
            q = ((m[i] << 30) + (len >> 1)) / len;
            o[i] = c[i] < 0 ? -longint'(q) : longint'(q);
        end
    endfunction

    function automatic void cross_vec(input longint a[3], input longint b[3],
                                      output longint o[3]);
        o[0] = a[1] * b[2] - a[2] * b[1];
        o[1] = a[2] * b[0] - a[0] * b[2];
        o[2] = a[0] * b[1] - a[1] * b[0];
    endfunction

    function automatic longint round_q30(longint v);
        longint unsigned r;
        r = (mag(v) + (64'd1 << 29)) >> 30;
        return v < 0 ? -longint'(r) : longint'(r);
    endfunction

    function automatic logic [31:0] translate(longint row[3], longint p[3]);
        longint t;
        t = -round_q30(row[0] * p[0] + row[1] * p[1] + row[2] * p[2]);
        if (t > 64'sd2147483647) t = 64'sd2147483647;
        if (t < -64'sd2147483648) t = -64'sd2147483648;
        return t[31:0];
    endfunction

    function automatic t_view predict_view(t_cam c);
        longint p[3], a[3], up[3], w[3], cu[3], u[3], cv[3], v[3];
        t_view r;
        p = '{longint'($signed(c.px)), longint'($signed(c.py)), longint'($signed(c.pz))};
        a = '{longint'($signed(c.ax)), longint'($signed(c.ay)), longint'($signed(c.az))};
        up = '{longint'($signed(c.ux)), longint'($signed(c.uy)), longint'($signed(c.uz))};
        if (c.action)
            for (int i = 0; i < 3; i++) a[i] -= p[i];
        unit_vec(a, w);
        cross_vec(w, up, cu);
        unit_vec(cu, u);
        cross_vec(w, u, cv);
        for (int i = 0; i < 3; i++) begin
            v[i] = round_q30(cv[i]);
            if (v[i] > 64'sd1073741824) v[i] = 64'sd1073741824;
            if (v[i] < -64'sd1073741824) v[i] = -64'sd1073741824;
        end
        r.rx = u[0][31:0]; r.ry = u[1][31:0]; r.rz = u[2][31:0];
        r.vx = v[0][31:0]; r.vy = v[1][31:0]; r.vz = v[2][31:0];
        r.fx = w[0][31:0]; r.fy = w[1][31:0]; r.fz = w[2][31:0];
        r.sx = translate(u, p);
        r.sy = translate(v, p);
        r.sz = translate(w, p);
        return r;
    endfunction

    // random field: extremes, small values or full range
    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 7))
            0: return MIN32;
            1: return MAX32;
            2: return 32'($signed($urandom_range(0, 8)) - 4) << 16;
            3, 4: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
            default: return $urandom;
        endcase
    endfunction

    function automatic t_cam rand_cam();
        t_cam c;
        c.action = 1'($urandom_range(0, 1));
        c.px = rand_coord(); c.py = rand_coord(); c.pz = rand_coord();
        c.ax = rand_coord(); c.ay = rand_coord(); c.az = rand_coord();
        c.ux = rand_coord(); c.uy = rand_coord(); c.uz = rand_coord();
        // sometimes make the aim degenerate, the up zero, or the up parallel to the aim
        case ($urandom_range(0, 19))
            0: if (c.action) {c.ax, c.ay, c.az} = {c.px, c.py, c.pz};
               else {c.ax, c.ay, c.az} = '0;
            1: {c.ux, c.uy, c.uz} = '0;
            2: if (!c.action) {c.ux, c.uy, c.uz} = {c.ax, c.ay, c.az};
            default: ;
        endcase
        return c;
    endfunction

    // present one request, then hold start low for a random gap, which may be zero
    task automatic send_request(t_cam c);
        int gap;
        i_action <= c.action;
        {i_pos_x, i_pos_y, i_pos_z} <= {c.px, c.py, c.pz};
        {i_aim_x, i_aim_y, i_aim_z} <= {c.ax, c.ay, c.az};
        {i_up_x, i_up_y, i_up_z} <= {c.ux, c.uy, c.uz};
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
        pending_views.push_back(predict_view(c));
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
        @(negedge i_clk);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    function automatic t_row mk(t_cam c, bit chk, t_view f);
        t_row r;
        r.cam = c;
        r.check_fixed = chk;
        r.fixed = f;
        return r;
    endfunction

    // compare each accepted result with the oldest expectation
    always @(posedge i_clk) begin
        t_view exp_v, got;
        if (i_rst_n && o_valid) begin
            got = {o_right_x, o_right_y, o_right_z, o_upward_x, o_upward_y, o_upward_z,
                   o_forward_x, o_forward_y, o_forward_z, o_shift_x, o_shift_y, o_shift_z};
            if (pending_views.size() == 0) begin
                $error("unexpected result");
                fail_count++;
            end else begin
                exp_v = pending_views.pop_front();
                for (int i = 11; i >= 0; i--) begin
                    if (got[i*32 +: 32] !== exp_v[i*32 +: 32]) begin
                        $error("%s: expected %h, got %h",
                               field_names[i], exp_v[i*32 +: 32], got[i*32 +: 32]);
                        fail_count++;
                    end
                end
            end
        end
    end

    initial begin
        t_row  rows[$];
        t_view zero_v, fwd_x;
        t_cam  c;
        int    waited;
        zero_v = '0;
        // w along +x, every other field zero
        fwd_x = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // zero aim, zero target offset: everything zero
        c = '0;
        rows.push_back(mk(c, 1, zero_v));
        c = '{1'b1, MAX32, MIN32, 32'h1234, MAX32, MIN32, 32'h1234, 0, ONE_Q30, 0};
        rows.push_back(mk(c, 1, zero_v));
        // up zero: only w and shift_z survive; at position zero shift_z is zero
        c = '{1'b0, 0, 0, 0, 32'h0001_0000, 0, 0, 0, 0, 0};
        fwd_x.fx = ONE_Q30;
        rows.push_back(mk(c, 1, fwd_x));
        // up parallel to aim
        c = '{1'b0, 0, 0, 0, 32'h0001_0000, 0, 0, 32'h0005_0000, 0, 0};
        rows.push_back(mk(c, 1, fwd_x));
        c = '{1'b0, 0, 0, 0, 1, 0, 0, MIN32, 0, 0};
        rows.push_back(mk(c, 1, fwd_x));
        // predictor-checked rows: extremes and both actions
        rows.push_back(mk('{1'b0, 0, 0, 32'h0005_0000, 0, 0, 32'hffff_0000,
                            0, 32'h0001_0000, 0}, 0, zero_v));
        rows.push_back(mk('{1'b1, MAX32, MAX32, MAX32, MIN32, MIN32, MIN32,
                            MIN32, MAX32, MIN32}, 0, zero_v));
        rows.push_back(mk('{1'b1, MIN32, MIN32, MIN32, MAX32, MAX32, MAX32,
                            MAX32, MIN32, MAX32}, 0, zero_v));
        rows.push_back(mk('{1'b0, MAX32, MIN32, MAX32, MIN32, MAX32, 1,
                            1, 1, MIN32}, 0, zero_v));
        rows.push_back(mk('{1'b0, MIN32, MAX32, MIN32, 1, 32'hffff_ffff, 0,
                            0, 0, 1}, 0, zero_v));
        rows.push_back(mk('{1'b1, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
                            32'h0001_0000, 32'h0002_0000, 32'h0004_0000,
                            0, 32'h0001_0000, 0}, 0, zero_v));
        rows.push_back(mk('{1'b0, 32'haaaa_aaaa, 32'h5555_5555, 32'hffff_ffff,
                            32'h5555_5555, 32'haaaa_aaaa, 32'h8000_0001,
                            32'h7fff_fffe, 32'h0000_0001, 32'hfffe_0000}, 0, zero_v));

        foreach (rows[k]) begin
            if (rows[k].check_fixed && predict_view(rows[k].cam) !== rows[k].fixed) begin
                $error("directed row %0d: typed-in result disagrees with prediction", k);
                fail_count++;
            end
            send_request(rows[k].cam);
        end
        repeat (RAND_ITEMS) send_request(rand_cam());
        start <= 1'b0;

        // drain: wait for the outstanding results to arrive
        waited = 0;
        while (pending_views.size() != 0 && waited < 2000) begin
            @(negedge i_clk);
            waited++;
        end
        repeat (200) @(negedge i_clk);
        if (pending_views.size() != 0) begin
            $error("%0d results never arrived", pending_views.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
